FILE: hw/rtl/cpvt_pkg.sv
`timescale 1ns / 1ps

package cpvt_pkg;

  // Default sizing of the vote store.
  localparam int DefNumVariables = 4096;
  localparam int DefVoteBits     = 32;
  localparam int DefFractionBits = 16;

  // Fixed field widths.
  localparam int VarIndexBits  = 12;
  localparam int ClauseSizeBits = 8;
  localparam int WeightBits    = 17;
  localparam int ResultBits    = 32;
  localparam int CfgIndexBits  = 1;

  // Clauses longer than this carry no weight.
  localparam logic [ClauseSizeBits-1:0] MaxClauseSize = 8'd63;

  // Operation codes.
  localparam logic [1:0] OP_VOTE  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Clause kinds.
  localparam logic [1:0] KIND_LONG    = 2'd0;
  localparam logic [1:0] KIND_BINARY  = 2'd1;
  localparam logic [1:0] KIND_TERNARY = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CfgIndexBits-1:0] CFG_BINARY_WEIGHT  = 1'd0;
  localparam logic [CfgIndexBits-1:0] CFG_TERNARY_WEIGHT = 1'd1;
  localparam logic [WeightBits-1:0]   BinaryWeightReset  = 17'd32768;
  localparam logic [WeightBits-1:0]   TernaryWeightReset = 17'd19661;

  // One request into the table.
  typedef struct packed {
    logic [1:0]                operation;
    logic [VarIndexBits-1:0]   variable_index;
    logic                      literal_sign;
    logic [ClauseSizeBits-1:0] clause_size;
    logic [1:0]                implicit_kind;
    logic                      redundant_clause;
  } vote_req_t;

  // One result out of the table.
  typedef struct packed {
    logic                         polarity_true;
    logic                         undecided;
    logic signed [ResultBits-1:0] vote_value;
    logic                         saturated;
  } vote_rsp_t;

endpackage

FILE: hw/rtl/clause_polarity_vote_table_core.sv
`timescale 1ns / 1ps

// Polarity vote table. Each request votes for one literal, queries one variable or
// clears one entry, and yields exactly one result, strobed on rsp_valid_o for one cycle
// once it has passed the read stage and the result register; the receiver cannot stall,
// so results must be captured when strobed. A request is taken whenever start is high and
// busy is low, one per cycle: the vote store is a single-read, single-write memory and
// each request does one read-modify-write, with the previous write forwarded when it
// hits the same entry. After reset the block clears every entry of the store with busy high.
// Configuration writes are always ready but must only be issued while the table is idle.
module clause_polarity_vote_table_core import cpvt_pkg::*; #(
  parameter int NUM_VARIABLES = DefNumVariables,
  parameter int VOTE_BITS     = DefVoteBits,
  parameter int FRACTION_BITS = DefFractionBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  vote_req_t               req_i,
  output logic                    rsp_valid_o,
  output vote_rsp_t               rsp_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [WeightBits-1:0]   cfg_data_i
);

  localparam int AW = $clog2(NUM_VARIABLES);
  localparam int CW = ((AW > VarIndexBits) ? AW : VarIndexBits) + 1;

  logic                  accept;
  logic [AW-1:0]         req_addr;
  logic                  req_in_range;

  logic                  clearing_q;
  logic [AW-1:0]         clr_cnt_q;

  logic [WeightBits-1:0] binary_weight_q;
  logic [WeightBits-1:0] ternary_weight_q;

  logic                  s1_valid_q;
  vote_req_t             s1_req_q;
  logic [AW-1:0]         s1_addr_q;
  logic                  s1_in_range_q;

  logic                  fwd_valid_q;
  logic [AW-1:0]         fwd_addr_q;
  logic [VOTE_BITS-1:0]  fwd_data_q;

  logic [VOTE_BITS-1:0]  ram_rdata;
  logic [VOTE_BITS-1:0]  cur_vote;
  logic [VOTE_BITS-1:0]  new_vote;
  logic                  new_sat;
  logic                  item_we;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VOTE_BITS-1:0]  ram_wdata;

  logic                  rsp_valid_q;
  vote_rsp_t             rsp_q;
  vote_rsp_t             rsp_d;

  // Request handshake and address decode.
  assign busy         = clearing_q;
  assign accept       = start && !clearing_q;
  assign req_addr     = AW'(req_i.variable_index);
  assign req_in_range = CW'(req_i.variable_index) < CW'(NUM_VARIABLES);

  // Clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(NUM_VARIABLES - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_weight_q  <= BinaryWeightReset;
      ternary_weight_q <= TernaryWeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BINARY_WEIGHT:  binary_weight_q  <= cfg_data_i;
        CFG_TERNARY_WEIGHT: ternary_weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Read stage: the request waits here for the memory data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q      <= req_i;
      s1_addr_q     <= req_addr;
      s1_in_range_q <= req_in_range;
    end
  end

  // Vote store.
  cpvt_ram #(
    .Width (VOTE_BITS),
    .Depth (NUM_VARIABLES)
  ) u_vote_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (req_addr),
    .rdata_o (ram_rdata)
  );

  // The previous request's write-back is not yet visible in the read data.
  assign cur_vote = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;

  cpvt_update #(
    .VoteBits     (VOTE_BITS),
    .FractionBits (FRACTION_BITS)
  ) u_update (
    .req_i            (s1_req_q),
    .vote_i           (cur_vote),
    .binary_weight_i  (binary_weight_q),
    .ternary_weight_i (ternary_weight_q),
    .vote_o           (new_vote),
    .saturated_o      (new_sat)
  );

  // Write-back, shared with the clearing pass.
  assign item_we   = s1_valid_q && s1_in_range_q;
  assign ram_we    = item_we || clearing_q;
  assign ram_waddr = clearing_q ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = clearing_q ? '0 : new_vote;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= item_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_vote;
    end
  end

  // Result formatting; an index beyond the table reports a zero vote.
  always_comb begin
    if (s1_in_range_q) begin
      rsp_d.polarity_true = !new_vote[VOTE_BITS-1];
      rsp_d.undecided     = (new_vote == '0);
      rsp_d.vote_value    = ResultBits'($signed(new_vote));
      rsp_d.saturated     = new_sat;
    end else begin
      rsp_d.polarity_true = 1'b1;
      rsp_d.undecided     = 1'b1;
      rsp_d.vote_value    = '0;
      rsp_d.saturated     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: hw/rtl/cpvt_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module cpvt_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read of the entry being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/cpvt_update.sv
`timescale 1ns / 1ps

// Computes the new vote of one entry: weight selection and saturating add or subtract.
module cpvt_update import cpvt_pkg::*; #(
  parameter int VoteBits     = DefVoteBits,
  parameter int FractionBits = DefFractionBits
) (
  input  vote_req_t             req_i,
  input  logic [VoteBits-1:0]   vote_i,
  input  logic [WeightBits-1:0] binary_weight_i,
  input  logic [WeightBits-1:0] ternary_weight_i,
  output logic [VoteBits-1:0]   vote_o,
  output logic                  saturated_o
);

  localparam int WW = (FractionBits + 1 > WeightBits) ? FractionBits + 1 : WeightBits;
  localparam int SW = ((VoteBits > WW) ? VoteBits : WW) + 2;
  localparam logic [SW-1:0] VoteMax = {{(SW - VoteBits + 1){1'b0}}, {(VoteBits - 1){1'b1}}};
  localparam logic [SW-1:0] VoteMin = {{(SW - VoteBits + 1){1'b1}}, {(VoteBits - 1){1'b0}}};

  logic [WW-1:0]       long_weight;
  logic [WW-1:0]       weight;
  logic                kind_ok;
  logic [5:0]          exponent;
  logic [SW-1:0]       vote_ext;
  logic [SW-1:0]       weight_ext;
  logic [SW-1:0]       sum;
  logic                over;
  logic                under;

  // Long clauses weigh 2^-(size-1), truncated to the fraction bits.
  always_comb begin
    exponent    = 6'(req_i.clause_size - 8'd1);
    long_weight = '0;
    if ((req_i.clause_size != '0) && (req_i.clause_size <= MaxClauseSize) &&
        (7'(FractionBits) >= {1'b0, exponent})) begin
      long_weight = WW'(1) << (7'(FractionBits) - {1'b0, exponent});
    end
  end

  // Weight by clause kind; the unused kind code casts no vote.
  always_comb begin
    kind_ok = 1'b1;
    case (req_i.implicit_kind)
      KIND_LONG:    weight = long_weight;
      KIND_BINARY:  weight = WW'(binary_weight_i);
      KIND_TERNARY: weight = WW'(ternary_weight_i);
      default: begin
        weight  = '0;
        kind_ok = 1'b0;
      end
    endcase
  end

  // Saturating add or subtract in a wide signed domain.
  always_comb begin
    vote_ext   = {{(SW - VoteBits){vote_i[VoteBits-1]}}, vote_i};
    weight_ext = {{(SW - WW){1'b0}}, weight};
    sum        = req_i.literal_sign ? (vote_ext + weight_ext) : (vote_ext - weight_ext);
    over       = $signed(sum) > $signed(VoteMax);
    under      = $signed(sum) < $signed(VoteMin);
  end

  // Apply the operation to the entry.
  always_comb begin
    vote_o      = vote_i;
    saturated_o = 1'b0;
    case (req_i.operation)
      OP_CLEAR: vote_o = '0;
      OP_VOTE: begin
        if (!req_i.redundant_clause && kind_ok) begin
          if (over) begin
            vote_o      = VoteMax[VoteBits-1:0];
            saturated_o = 1'b1;
          end else if (under) begin
            vote_o      = VoteMin[VoteBits-1:0];
            saturated_o = 1'b1;
          end else begin
            vote_o = sum[VoteBits-1:0];
          end
        end
      end
      default: vote_o = vote_i;
    endcase
  end

endmodule
